FILE: hw/rtl/ssm_pkg.sv
// shared types, sizes and helpers for the sequence sublist matcher
`default_nettype none

package ssm_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int VALUE_W     = 32;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

    typedef enum logic [1:0] {
        ACT_PATTERN       = 2'd0,
        ACT_TEXT          = 2'd1,
        ACT_EMPTY_PATTERN = 2'd2,
        ACT_EMPTY_TEXT    = 2'd3
    } action_t;

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [LEN_W-1:0]      len_t;

    typedef struct packed {
        logic step;
        logic clear;
    } cell_ctl_t;

    function automatic data_t to_data(input logic [VALUE_W-1:0] v);
        logic [2*VALUE_W-1:0] wide;
        wide = {{VALUE_W{1'b0}}, v};
        return wide[DATA_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ssm_cell.sv
// one pattern position: stored element and its prefix match bit
`default_nettype none

module ssm_cell (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ssm_pkg::cell_ctl_t ctl,
    input  wire logic              wr_en,
    input  wire logic              active,
    input  wire logic              tail,
    input  wire ssm_pkg::data_t    value,
    input  wire logic              prev_bit,
    output logic                   bit_o,
    output logic                   hit_o
);
    import ssm_pkg::*;

    data_t pat_reg;
    logic  bit_reg;
    logic  bit_next;

    assign bit_next = prev_bit && (pat_reg == value);
    assign bit_o    = bit_reg;
    assign hit_o    = tail && bit_next;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pat_reg <= value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg <= 1'b0;
        end else if (ctl.clear) begin
            bit_reg <= 1'b0;
        end else if (ctl.step && active) begin
            bit_reg <= bit_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sequence_sublist_matcher_unit.sv
// top level of the sequence sublist matcher: control, cell row and result register
//
// channel | ports    | contents
// --------+----------+-------------------------------------------------
// input   | s_t*     | tdata value, tuser action, tlast last element
// result  | m_t*     | tdata bit 0 found, bit 1 pattern overflow
//
// one transfer per cycle on the input while s_tready is high; every element is handled in the cycle it is taken
// a result shows on m_tvalid the cycle after the last text element or an empty text item
// the row of MAX_PATTERN cells updates all match bits at once, so no item waits on another
// input is held off only while a result sits unaccepted in the output register
// reset empties the pattern and clears all match bits; stored elements need no reset
`default_nettype none

module sequence_sublist_matcher_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [ssm_pkg::VALUE_W-1:0]   s_tdata,   // value
    input  wire logic [1:0]                    s_tuser,   // action
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [7:0]                         m_tdata    // found, pattern_overflow, zero fill
);
    import ssm_pkg::*;

    len_t    len_reg, len_next;
    logic    ovf_reg, ovf_next;
    logic    seen_reg, seen_next;
    logic    loading_reg, loading_next;
    logic    m_tvalid_reg, m_tvalid_next;
    logic    found_reg, found_next;
    logic    m_ovf_reg, m_ovf_next;

    logic      acc;
    action_t   act;
    data_t     val;
    len_t      eff_len;
    cell_ctl_t ctl;
    logic      wr_ok;
    logic [MAX_PATTERN-1:0] wr_sel;
    logic [MAX_PATTERN-1:0] active;
    logic [MAX_PATTERN-1:0] tail;
    logic [MAX_PATTERN-1:0] bits;
    logic [MAX_PATTERN-1:0] hits;
    logic      hit_now;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign acc      = s_tvalid && s_tready;
    assign act      = action_t'(s_tuser);
    assign val      = to_data(s_tdata);
    assign eff_len  = loading_reg ? '0 : len_reg;
    assign wr_ok    = acc && (act == ACT_PATTERN) && (eff_len < len_t'(MAX_PATTERN));
    assign hit_now  = |hits;

    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            wr_sel[i] = wr_ok && (eff_len == len_t'(i));
            active[i] = len_reg > len_t'(i);
            tail[i]   = len_reg == len_t'(i + 1);
        end
    end

    always_comb begin
        ctl.step  = acc && (act == ACT_TEXT);
        ctl.clear = acc && (((act == ACT_PATTERN) && loading_reg)
                            || (act == ACT_EMPTY_PATTERN)
                            || (act == ACT_EMPTY_TEXT)
                            || ((act == ACT_TEXT) && s_tlast));
    end

    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
        ssm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .wr_en    (wr_sel[g]),
            .active   (active[g]),
            .tail     (tail[g]),
            .value    (val),
            .prev_bit ((g == 0) ? 1'b1 : bits[(g == 0) ? 0 : g - 1]),
            .bit_o    (bits[g]),
            .hit_o    (hits[g])
        );
    end

    always_comb begin
        len_next      = len_reg;
        ovf_next      = ovf_reg;
        seen_next     = seen_reg;
        loading_next  = loading_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        found_next    = found_reg;
        m_ovf_next    = m_ovf_reg;
        if (acc) begin
            case (act)
                ACT_PATTERN: begin
                    if (loading_reg) begin
                        ovf_next  = 1'b0;
                        seen_next = 1'b0;
                    end
                    if (wr_ok) begin
                        len_next = eff_len + len_t'(1);
                    end else begin
                        len_next = eff_len;
                        ovf_next = 1'b1;
                    end
                    loading_next = s_tlast;
                end
                ACT_EMPTY_PATTERN: begin
                    len_next     = '0;
                    ovf_next     = 1'b0;
                    seen_next    = 1'b0;
                    loading_next = 1'b1;
                end
                ACT_EMPTY_TEXT: begin
                    loading_next  = 1'b1;
                    seen_next     = 1'b0;
                    m_tvalid_next = 1'b1;
                    found_next    = (len_reg == '0) && !ovf_reg;
                    m_ovf_next    = ovf_reg;
                end
                ACT_TEXT: begin
                    loading_next = 1'b1;
                    if (s_tlast) begin
                        seen_next     = 1'b0;
                        m_tvalid_next = 1'b1;
                        found_next    = (seen_reg || hit_now) && (len_reg != '0) && !ovf_reg;
                        m_ovf_next    = ovf_reg;
                    end else if (hit_now) begin
                        seen_next = 1'b1;
                    end
                end
                default: begin
                    loading_next = loading_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
            seen_reg     <= 1'b0;
            loading_reg  <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            len_reg      <= len_next;
            ovf_reg      <= ovf_next;
            seen_reg     <= seen_next;
            loading_reg  <= loading_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        found_reg <= found_next;
        m_ovf_reg <= m_ovf_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_ovf_reg, found_reg};

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= len_t'(MAX_PATTERN))
        else $error("pattern length beyond capacity");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (len_reg == len_t'(MAX_PATTERN)))
        else $error("overflow flagged with room left");

    a_seen_len: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg |-> (len_reg != '0))
        else $error("match seen with empty pattern");

    a_result_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("found given together with overflow");

    a_result_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && ((act == ACT_EMPTY_TEXT) || ((act == ACT_TEXT) && s_tlast))) |=> m_tvalid)
        else $error("end of text without result");

endmodule

`default_nettype wire
